// ===== rtl/led_matrix_row_scanner_top_assert.svh =====
// assertion macros for the led matrix row scanner checker
// no dependencies; included by files that hold concurrent assertions
`ifndef LED_MATRIX_ROW_SCANNER_TOP_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_TOP_ASSERT_SVH

// next-cycle implication, ignored while reset is high
`define LMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, checked through reset as well
`define LMRS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/lmrs_pkg.sv =====
// shared types and constants for the led matrix row scanner
// no dependencies; used by the front, queue, back and top modules of the block
package lmrs_pkg;

  // command codes on the cmd port
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_REARM = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  // fixed geometry of the frame store (rows and bytes per half it can hold)
  localparam int STORE_ROWS   = 16;
  localparam int STORE_BYTES  = 8;
  localparam int HALF_ADDR_W  = $clog2(STORE_ROWS * STORE_BYTES);
  localparam int ROW_ADDR_W   = 5;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic {
    JOB_WRITE,
    JOB_SCAN
  } job_kind_t;

  // one classified request handed from front to back
  typedef struct packed {
    job_kind_t              kind;
    logic                   half_sel;
    logic [ROW_ADDR_W-1:0]  row;
    logic [2:0]             byte_idx;
    logic [7:0]             data;
    logic                   blank_u;
    logic                   blank_l;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT
  } scan_state_t;

endpackage

// ===== rtl/lmrs_front.sv =====
// front end: accepts requests, keeps the row counter and classifies jobs
// depends on lmrs_pkg
module lmrs_front #(
  parameter int ROWS_PER_HALF = 16,
  parameter int BYTES_PER_ROW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              q_full,
  input  logic [1:0]        cmd,
  input  logic              half_select,
  input  logic [3:0]        row_index,
  input  logic [2:0]        byte_index,
  input  logic [7:0]        pixel_byte,
  input  logic              blank_upper,
  input  logic              blank_lower,
  output logic              push,
  output lmrs_pkg::job_t    job
);

  localparam int RW = $clog2(ROWS_PER_HALF + 1);
  localparam logic [5:0] ROWS_LIMIT  = 6'(ROWS_PER_HALF);
  localparam logic [3:0] BYTES_LIMIT = 4'(BYTES_PER_ROW);

  logic          accept;
  logic [RW-1:0] rows_left;
  logic [RW-1:0] rows_left_next;
  logic [RW-1:0] row_dec;
  logic          write_ok;

  assign accept   = start && !q_full;
  assign row_dec  = rows_left - 1'b1;
  assign write_ok = ({2'b00, row_index} < ROWS_LIMIT) && ({1'b0, byte_index} < BYTES_LIMIT);

  // classify the request and build the job
  always_comb begin
    rows_left_next = rows_left;
    push           = 1'b0;
    job.kind       = lmrs_pkg::JOB_WRITE;
    job.half_sel   = half_select;
    job.row        = {1'b0, row_index};
    job.byte_idx   = byte_index;
    job.data       = pixel_byte;
    job.blank_u    = blank_upper;
    job.blank_l    = blank_lower;
    if (accept) begin
      unique case (cmd)
        lmrs_pkg::CMD_WRITE: begin
          push = write_ok;
        end
        lmrs_pkg::CMD_REARM: begin
          rows_left_next = RW'(ROWS_PER_HALF);
        end
        lmrs_pkg::CMD_SCAN: begin
          if (rows_left != '0) begin
            rows_left_next = row_dec;
            push           = 1'b1;
            job.kind       = lmrs_pkg::JOB_SCAN;
            job.row        = lmrs_pkg::ROW_ADDR_W'(row_dec);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_left <= '0;
    end else begin
      rows_left <= rows_left_next;
    end
  end

endmodule

// ===== rtl/lmrs_queue.sv =====
// short job queue between front and back
// depends on lmrs_pkg
module lmrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lmrs_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output lmrs_pkg::job_t head_job
);

  localparam int DEPTH = lmrs_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  lmrs_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/lmrs_back.sv =====
// back end: frame store and the row shift sequencer
// depends on lmrs_pkg
module lmrs_back #(
  parameter int BYTES_PER_ROW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  lmrs_pkg::job_t                    q_job,
  output logic                              q_pop,
  output logic                              result_strobe,
  output logic                              upper_bit,
  output logic                              lower_bit,
  output logic [lmrs_pkg::ROW_ADDR_W-1:0]   row_address,
  output logic                              last_bit
);

  localparam int AW = lmrs_pkg::HALF_ADDR_W;
  localparam int NE = 1 << AW;
  localparam logic [2:0] LAST_BYTE = 3'(BYTES_PER_ROW - 1);

  lmrs_pkg::scan_state_t state;
  lmrs_pkg::scan_state_t state_next;

  logic [7:0]    mem_up [NE];
  logic [7:0]    mem_lo [NE];
  logic [NE-1:0] valid_up;
  logic [NE-1:0] valid_lo;

  lmrs_pkg::job_t job;
  logic [2:0]     byte_pos;
  logic [2:0]     bit_cnt;
  logic [2:0]     rd_byte;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           do_write;
  logic [7:0]     rd_up;
  logic [7:0]     rd_lo;
  logic [7:0]     sh_up;
  logic [7:0]     sh_lo;
  logic [7:0]     cur_up;
  logic [7:0]     cur_lo;
  logic           row_end;

  assign row_end = (byte_pos == LAST_BYTE) && (bit_cnt == 3'd7);
  assign rd_addr = {job.row[3:0], rd_byte};
  assign wr_addr = {q_job.row[3:0], q_job.byte_idx};
  assign cur_up  = (bit_cnt == 3'd0) ? rd_up : sh_up;
  assign cur_lo  = (bit_cnt == 3'd0) ? rd_lo : sh_lo;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, queue pop and read address
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_write   = 1'b0;
    rd_byte    = byte_pos;
    unique case (state)
      lmrs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_job.kind == lmrs_pkg::JOB_WRITE) begin
            do_write = 1'b1;
          end else begin
            state_next = lmrs_pkg::ST_LOAD;
          end
        end
      end
      lmrs_pkg::ST_LOAD: begin
        rd_byte    = 3'd0;
        state_next = lmrs_pkg::ST_SHIFT;
      end
      lmrs_pkg::ST_SHIFT: begin
        if (bit_cnt == 3'd7) begin
          rd_byte = byte_pos + 3'd1;
          if (byte_pos == LAST_BYTE) begin
            state_next = lmrs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lmrs_pkg::ST_IDLE;
      end
    endcase
  end

  // frame store arrays, one per half
  always_ff @(posedge clk) begin
    if (do_write && !q_job.half_sel) begin
      mem_up[wr_addr] <= q_job.data;
    end
    if (do_write && q_job.half_sel) begin
      mem_lo[wr_addr] <= q_job.data;
    end
    rd_up <= valid_up[rd_addr] ? mem_up[rd_addr] : 8'h00;
    rd_lo <= valid_lo[rd_addr] ? mem_lo[rd_addr] : 8'h00;
  end

  // written marks, cleared by reset so the panel starts dark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_up <= '0;
      valid_lo <= '0;
    end else if (do_write) begin
      if (q_job.half_sel) begin
        valid_lo[wr_addr] <= 1'b1;
      end else begin
        valid_up[wr_addr] <= 1'b1;
      end
    end
  end

  // current scan job
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

  // byte and bit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      bit_cnt  <= '0;
    end else if (state == lmrs_pkg::ST_LOAD) begin
      byte_pos <= '0;
      bit_cnt  <= '0;
    end else if (state == lmrs_pkg::ST_SHIFT) begin
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        byte_pos <= byte_pos + 3'd1;
      end
    end
  end

  // shift registers and result payload
  always_ff @(posedge clk) begin
    if (state == lmrs_pkg::ST_SHIFT) begin
      sh_up       <= {cur_up[6:0], 1'b0};
      sh_lo       <= {cur_lo[6:0], 1'b0};
      upper_bit   <= cur_up[7] & ~job.blank_u;
      lower_bit   <= cur_lo[7] & ~job.blank_l;
      row_address <= job.row;
      last_bit    <= row_end;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == lmrs_pkg::ST_SHIFT);
    end
  end

endmodule

// ===== rtl/led_matrix_row_scanner_top.sv =====
// Row scan driver for a two-half LED matrix panel. Requests are taken when
// start is high and busy is low; busy only rises when the two-entry job queue
// is full. A write request is popped and stored by the back end; a rearm is
// done in the front end at once. A scan of a row in the back end takes the job
// from the queue, reads the frame store, then gives one result per cycle.
// Results come out one bit pair per cycle on result_strobe and cannot be held
// off, so the receiver must take every strobed result. A scan with the row
// counter at zero, an unused command and an out-of-range write give no
// results.
// depends on lmrs_pkg, lmrs_front, lmrs_queue, lmrs_back
module led_matrix_row_scanner_top #(
  parameter int ROWS_PER_HALF = 16,
  parameter int BYTES_PER_ROW = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic        half_select,
  input  logic [3:0]  row_index,
  input  logic [2:0]  byte_index,
  input  logic [7:0]  pixel_byte,
  input  logic        blank_upper,
  input  logic        blank_lower,
  output logic        result_strobe,
  output logic        upper_bit,
  output logic        lower_bit,
  output logic [4:0]  row_address,
  output logic        last_bit
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  lmrs_pkg::job_t push_job;
  lmrs_pkg::job_t head_job;

  assign busy = q_full;

  // request classification and row counter
  lmrs_front #(
    .ROWS_PER_HALF(ROWS_PER_HALF),
    .BYTES_PER_ROW(BYTES_PER_ROW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .q_full     (q_full),
    .cmd        (cmd),
    .half_select(half_select),
    .row_index  (row_index),
    .byte_index (byte_index),
    .pixel_byte (pixel_byte),
    .blank_upper(blank_upper),
    .blank_lower(blank_lower),
    .push       (push),
    .job        (push_job)
  );

  // job queue
  lmrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(q_valid),
    .head_job  (head_job)
  );

  // frame store and shifter
  lmrs_back #(
    .BYTES_PER_ROW(BYTES_PER_ROW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .result_strobe(result_strobe),
    .upper_bit    (upper_bit),
    .lower_bit    (lower_bit),
    .row_address  (row_address),
    .last_bit     (last_bit)
  );

endmodule

// ===== rtl/lmrs_checker.sv =====
// port-level checks for the led matrix row scanner, bound to the top level
// depends on led_matrix_row_scanner_top_assert.svh and led_matrix_row_scanner_top
`include "led_matrix_row_scanner_top_assert.svh"

module lmrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_strobe,
  input logic [4:0] row_address,
  input logic       last_bit
);

  // a row streams without gaps and keeps one row address
  `LMRS_ASSERT_NEXT(a_row_stream, clk, rst, result_strobe && !last_bit, result_strobe && $stable(row_address))

  // the return to idle and the store read of the next row leave a gap after the last bit
  `LMRS_ASSERT_NEXT(a_gap_after_row, clk, rst, result_strobe && last_bit, !result_strobe)

  // reset leaves no result in flight
  `LMRS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !result_strobe)

  // reset empties the job queue
  `LMRS_ASSERT_NEXT_ALWAYS(a_reset_ready, clk, rst, !busy)

endmodule

bind led_matrix_row_scanner_top lmrs_checker u_lmrs_checker (.*);
